// ----- rtl/mp2a_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared types and constants of the 2-D max pooling block with argmax.
// ----------------------------------------------------------------------------
package mp2a_pkg;

    localparam int IDX_W      = 20;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_POOL_W = 5;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_MAX_POOL    = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int FQ_DEPTH = 4;
    localparam int OQ_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_HEIGHT  = 2'd3;

    typedef struct packed {
        logic first;
        logic emit;
        logic eop;
    } t_flags;

endpackage

// ----- rtl/mp2a_fifo.sv -----
// ----------------------------------------------------------------------------
// mp2a_fifo
// Small register queue, power-of-two depth, head shown while not empty.
// ----------------------------------------------------------------------------
module mp2a_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/mp2a_ram.sv -----
// ----------------------------------------------------------------------------
// mp2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mp2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/mp2a_front.sv -----
// ----------------------------------------------------------------------------
// mp2a_front
// Configuration registers and raster position tracking; tags every
// accepted sample with its store slot, flat index and window flags.
// ----------------------------------------------------------------------------
module mp2a_front
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_POOL    = DEF_MAX_POOL,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                               i_cfg_data,
    input  logic                                                i_push,
    input  logic signed [SAMPLE_BITS-1:0]                       i_sample,
    input  logic                                                i_q_full,
    output logic                                                o_q_push,
    output logic signed [SAMPLE_BITS-1:0]                       o_q_sample,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_q_slot,
    output logic [IDX_W-1:0]                                    o_q_here,
    output t_flags                                              o_q_flags
);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WP_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int WR_W  = $clog2(MAX_WIDTH + 1);
    localparam int HR_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PR_W  = $clog2(MAX_POOL + 1);

    localparam int RST_WIDTH  = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int RST_HEIGHT = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;
    localparam int RST_POOL   = (MAX_POOL < 2) ? MAX_POOL : 2;

    logic [WR_W-1:0]  r_width;
    logic [HR_W-1:0]  r_height;
    logic [PR_W-1:0]  r_pool_w;
    logic [PR_W-1:0]  r_pool_h;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [WP_W-1:0]  r_wcol;
    logic [WP_W-1:0]  r_wrow;
    logic [COL_W-1:0] r_slot;
    logic [IDX_W-1:0] r_here;

    logic [CFG_SIZE_W-1:0] cfg_size;
    logic [CFG_POOL_W-1:0] cfg_pool;
    logic [WR_W-1:0]       n_width;
    logic [HR_W-1:0]       n_height;
    logic [PR_W-1:0]       n_pool;
    logic                  acc;
    logic                  last_col;
    logic                  last_row;
    logic                  wcol_wrap;
    logic                  wrow_wrap;

    assign cfg_size = i_cfg_data[CFG_SIZE_W-1:0];
    assign cfg_pool = i_cfg_data[CFG_POOL_W-1:0];

    always_comb begin
        if (cfg_size == '0) begin
            n_width  = WR_W'(1);
            n_height = HR_W'(1);
        end else begin
            n_width  = (32'(cfg_size) > MAX_WIDTH) ? WR_W'(MAX_WIDTH) : WR_W'(cfg_size);
            n_height = (32'(cfg_size) > MAX_HEIGHT) ? HR_W'(MAX_HEIGHT) : HR_W'(cfg_size);
        end
        if (cfg_pool == '0) begin
            n_pool = PR_W'(1);
        end else begin
            n_pool = (32'(cfg_pool) > MAX_POOL) ? PR_W'(MAX_POOL) : PR_W'(cfg_pool);
        end
    end

    assign acc       = i_push && !i_q_full;
    assign last_col  = (32'(r_col) + 32'd1 == 32'(r_width));
    assign last_row  = (32'(r_row) + 32'd1 == 32'(r_height));
    assign wcol_wrap = (32'(r_wcol) + 32'd1 == 32'(r_pool_w));
    assign wrow_wrap = (32'(r_wrow) + 32'd1 == 32'(r_pool_h));

    assign o_q_push        = acc;
    assign o_q_sample      = i_sample;
    assign o_q_slot        = r_slot;
    assign o_q_here        = r_here;
    assign o_q_flags.first = (r_wcol == '0) && (r_wrow == '0);
    assign o_q_flags.emit  = (last_col || wcol_wrap) && (last_row || wrow_wrap);
    assign o_q_flags.eop   = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WR_W'(RST_WIDTH);
            r_height <= HR_W'(RST_HEIGHT);
            r_pool_w <= PR_W'(RST_POOL);
            r_pool_h <= PR_W'(RST_POOL);
            r_col    <= '0;
            r_row    <= '0;
            r_wcol   <= '0;
            r_wrow   <= '0;
            r_slot   <= '0;
            r_here   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INPUT_WIDTH:  r_width  <= n_width;
                CFG_INPUT_HEIGHT: r_height <= n_height;
                CFG_POOL_WIDTH:   r_pool_w <= n_pool;
                CFG_POOL_HEIGHT:  r_pool_h <= n_pool;
                default: ;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_wcol <= '0;
            r_wrow <= '0;
            r_slot <= '0;
            r_here <= '0;
        end else if (acc) begin
            if (last_col) begin
                r_col  <= '0;
                r_wcol <= '0;
                r_slot <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_wrow <= '0;
                    r_here <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_wrow <= wrow_wrap ? '0 : r_wrow + WP_W'(1);
                    r_here <= r_here + IDX_W'(1);
                end
            end else begin
                r_col  <= r_col + COL_W'(1);
                r_wcol <= wcol_wrap ? '0 : r_wcol + WP_W'(1);
                r_slot <= wcol_wrap ? r_slot + COL_W'(1) : r_slot;
                r_here <= r_here + IDX_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mp2a_back.sv -----
// ----------------------------------------------------------------------------
// mp2a_back
// Row store of running window maxima and indices. One read-modify-write
// per cycle while results drain, forwarding back-to-back hits on one slot.
// ----------------------------------------------------------------------------
module mp2a_back
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_q_empty,
    output logic                                                o_q_pop,
    input  logic signed [SAMPLE_BITS-1:0]                       i_q_sample,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] i_q_slot,
    input  logic [IDX_W-1:0]                                    i_q_here,
    input  t_flags                                              i_q_flags,
    input  logic                                                i_res_full,
    output logic                                                o_res_push,
    output logic signed [SAMPLE_BITS-1:0]                       o_res_value,
    output logic [IDX_W-1:0]                                    o_res_index,
    output logic                                                o_res_eop
);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ENT_W = SAMPLE_BITS + IDX_W;

    logic                          r_b_valid;
    logic signed [SAMPLE_BITS-1:0] r_b_sample;
    logic [COL_W-1:0]              r_b_slot;
    logic [IDX_W-1:0]              r_b_here;
    t_flags                        r_b_flags;
    logic                          r_byp;
    logic signed [SAMPLE_BITS-1:0] r_byp_max;
    logic [IDX_W-1:0]              r_byp_idx;

    logic                          b_adv;
    logic                          b_load;
    logic [COL_W-1:0]              rd_addr;
    logic [ENT_W-1:0]              rdata;
    logic signed [SAMPLE_BITS-1:0] old_max;
    logic [IDX_W-1:0]              old_idx;
    logic                          take;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [IDX_W-1:0]              new_idx;

    assign b_adv   = r_b_valid && (!r_b_flags.emit || !i_res_full);
    assign b_load  = !i_q_empty && (!r_b_valid || b_adv);
    assign o_q_pop = b_load;
    assign rd_addr = b_load ? i_q_slot : r_b_slot;

    assign old_max = r_byp ? r_byp_max : rdata[IDX_W +: SAMPLE_BITS];
    assign old_idx = r_byp ? r_byp_idx : rdata[IDX_W-1:0];
    assign take    = r_b_flags.first || (r_b_sample > old_max);
    assign new_max = take ? r_b_sample : old_max;
    assign new_idx = take ? r_b_here : old_idx;

    assign o_res_push  = b_adv && r_b_flags.emit;
    assign o_res_value = new_max;
    assign o_res_index = new_idx;
    assign o_res_eop   = r_b_flags.eop;

    mp2a_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_slot),
        .i_wdata ({new_max, new_idx}),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            r_b_valid <= b_load || (r_b_valid && !b_adv);
            r_byp     <= b_adv && b_load && (i_q_slot == r_b_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_max <= new_max;
        r_byp_idx <= new_idx;
        if (b_load) begin
            r_b_sample <= i_q_sample;
            r_b_slot   <= i_q_slot;
            r_b_here   <= i_q_here;
            r_b_flags  <= i_q_flags;
        end
    end

endmodule

// ----- rtl/max_pool_2d_argmax.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_argmax
// 2-D max pooling with argmax over a raster stream, one plane after another.
//
// Input queue side: drive i_sample with i_push; an item is taken on a clock
// edge with i_push high and o_full low. One sample per cycle is sustained
// while results drain. Result queue side: while o_empty is low the oldest
// result is on o_pooled_value, o_source_index and o_end_of_plane; i_pop
// takes it. The sample closing a window passes the input queue and the
// row-store stage register before its result enters the result queue.
// The row store does one read and one write per cycle with a forwarding
// register. When the result side stalls, the result queue and then the
// 4-entry input queue fill and o_full rises; nothing is dropped.
// Registers must be written through i_cfg_wr_en / i_cfg_index / i_cfg_data
// only while the block is idle; it does not enforce this. Any write
// restarts the plane. Synchronous reset loads the default sizes and
// clears positions and queues. The row store needs no clearing: every
// window loads its first sample before it compares.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_POOL    = DEF_MAX_POOL,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_full,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    output logic [IDX_W-1:0]              o_source_index,
    output logic                          o_end_of_plane
);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FLG_W  = $bits(t_flags);
    localparam int FQ_W   = SAMPLE_BITS + COL_W + IDX_W + FLG_W;
    localparam int OQ_W   = SAMPLE_BITS + IDX_W + 1;

    logic                          fq_push;
    logic                          fq_full;
    logic                          fq_pop;
    logic                          fq_empty;
    logic [FQ_W-1:0]               fq_wdata;
    logic [FQ_W-1:0]               fq_rdata;
    logic signed [SAMPLE_BITS-1:0] f_sample;
    logic [COL_W-1:0]              f_slot;
    logic [IDX_W-1:0]              f_here;
    t_flags                        f_flags;
    logic signed [SAMPLE_BITS-1:0] b_sample;
    logic [COL_W-1:0]              b_slot;
    logic [IDX_W-1:0]              b_here;
    t_flags                        b_flags;

    logic                          oq_push;
    logic                          oq_full;
    logic [OQ_W-1:0]               oq_rdata;
    logic signed [SAMPLE_BITS-1:0] res_value;
    logic [IDX_W-1:0]              res_index;
    logic                          res_eop;

    assign o_full   = fq_full;
    assign fq_wdata = {f_sample, f_slot, f_here, f_flags};
    assign {b_sample, b_slot, b_here, b_flags} = fq_rdata;

    mp2a_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_POOL    (MAX_POOL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_sample    (i_sample),
        .i_q_full    (fq_full),
        .o_q_push    (fq_push),
        .o_q_sample  (f_sample),
        .o_q_slot    (f_slot),
        .o_q_here    (f_here),
        .o_q_flags   (f_flags)
    );

    mp2a_fifo #(
        .WIDTH (FQ_W),
        .DEPTH (FQ_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_wdata),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_empty (fq_empty),
        .o_data  (fq_rdata)
    );

    mp2a_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (fq_empty),
        .o_q_pop     (fq_pop),
        .i_q_sample  (b_sample),
        .i_q_slot    (b_slot),
        .i_q_here    (b_here),
        .i_q_flags   (b_flags),
        .i_res_full  (oq_full),
        .o_res_push  (oq_push),
        .o_res_value (res_value),
        .o_res_index (res_index),
        .o_res_eop   (res_eop)
    );

    mp2a_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  ({res_value, res_index, res_eop}),
        .o_full  (oq_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (oq_rdata)
    );

    assign {o_pooled_value, o_source_index, o_end_of_plane} = oq_rdata;

endmodule

// ----- sim/max_pool_2d_argmax_test.sv -----
// ----------------------------------------------------------------------------
// max_pool_2d_argmax_test
// Self-checking bench for the 2-D max pooling block with argmax. A driver
// feeds raster samples from a queue, a shadow of the pooling row store
// predicts every completed window, and a monitor pops results and checks
// value, source index and end-of-plane mark. Sizes are rewritten between
// idle phases: defaults, edge and partial windows, zero and oversize
// registers, then random shapes.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mp2a_pkg::*;

    localparam int SW             = DEF_SAMPLE_BITS;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;

    typedef enum int {
        SAMPLES_ANY,
        SAMPLES_TIES,
        SAMPLES_EXTREME
    } t_sample_mode;

    typedef struct {
        logic signed [SW-1:0] value;
        logic [IDX_W-1:0]     index;
        logic                 eop;
    } t_pooled;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_push      = 1'b0;
    logic signed [SW-1:0]  i_sample    = '0;
    logic                  o_full;
    logic                  i_pop       = 1'b0;
    logic                  o_empty;
    logic signed [SW-1:0]  o_pooled_value;
    logic [IDX_W-1:0]      o_source_index;
    logic                  o_end_of_plane;

    max_pool_2d_argmax uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .i_sample       (i_sample),
        .o_full         (o_full),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_pooled_value (o_pooled_value),
        .o_source_index (o_source_index),
        .o_end_of_plane (o_end_of_plane)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the pooling state
    int unsigned          row_len, plane_rows, win_w, win_h;
    int unsigned          col_at, row_at, win_col_at, win_row_at;
    logic signed [SW-1:0] run_max   [DEF_MAX_WIDTH];
    logic [IDX_W-1:0]     run_index [DEF_MAX_WIDTH];

    logic signed [SW-1:0] pending_samples [$];
    t_pooled              pool_results_due [$];

    int   items_queued = 0;
    int   items_taken  = 0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;
    int   send_gap, take_gap;
    bit   send_steady, take_steady;
    logic push_next, pop_next;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic signed [SW-1:0] draw_sample(t_sample_mode mode);
        logic signed [SW-1:0] v;
        case (mode)
            SAMPLES_TIES: begin
                v = SW'($urandom_range(0, 6));
                v = v - 3;
            end
            SAMPLES_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh7FFF;
                    1:       v = 16'sh8000;
                    2:       v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_POOL_W-1:0] pick_pool();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_POOL_W'($urandom_range(17, 31));
            2, 3:    return CFG_POOL_W'($urandom_range(6, 16));
            default: return CFG_POOL_W'($urandom_range(1, 5));
        endcase
    endfunction

    task automatic reset_shadow();
        row_len    = 32;
        plane_rows = 32;
        win_w      = 2;
        win_h      = 2;
        col_at     = 0;
        row_at     = 0;
        win_col_at = 0;
        win_row_at = 0;
    endtask

    task automatic apply_size_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INPUT_WIDTH:  row_len    = clamp_size(data, DEF_MAX_WIDTH);
            CFG_INPUT_HEIGHT: plane_rows = clamp_size(data, DEF_MAX_HEIGHT);
            CFG_POOL_WIDTH:   win_w      = clamp_size(data[CFG_POOL_W-1:0], DEF_MAX_POOL);
            CFG_POOL_HEIGHT:  win_h      = clamp_size(data[CFG_POOL_W-1:0], DEF_MAX_POOL);
            default: ;
        endcase
        col_at     = 0;
        row_at     = 0;
        win_col_at = 0;
        win_row_at = 0;
    endtask

    task automatic pool_sample(input logic signed [SW-1:0] s);
        int unsigned      slot;
        logic [IDX_W-1:0] here;
        bit               last_col, last_row;
        t_pooled          due;
        slot = col_at / win_w;
        if (slot >= DEF_MAX_WIDTH) slot = DEF_MAX_WIDTH - 1;
        here     = IDX_W'(row_at * row_len + col_at);
        last_col = (col_at + 1 >= row_len);
        last_row = (row_at + 1 >= plane_rows);
        if ((win_col_at == 0 && win_row_at == 0) || s > run_max[slot]) begin
            run_max[slot]   = s;
            run_index[slot] = here;
        end
        if ((last_col || win_col_at + 1 >= win_w) && (last_row || win_row_at + 1 >= win_h)) begin
            due.value = run_max[slot];
            due.index = run_index[slot];
            due.eop   = last_col && last_row;
            pool_results_due.push_back(due);
        end
        if (last_col) begin
            col_at     = 0;
            win_col_at = 0;
            if (last_row) begin
                row_at     = 0;
                win_row_at = 0;
            end else begin
                row_at++;
                win_row_at = (win_row_at + 1 >= win_h) ? 0 : win_row_at + 1;
            end
        end else begin
            col_at++;
            win_col_at = (win_col_at + 1 >= win_w) ? 0 : win_col_at + 1;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
            i_push      <= 1'b0;
            send_gap    = 0;
            send_steady = 1'b0;
        end else begin
            if (i_cfg_wr_en) apply_size_register(i_cfg_index, i_cfg_data);
            push_next = i_push;
            if (i_push && !o_full) begin
                pool_sample(i_sample);
                items_taken++;
                push_next = 1'b0;
                if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
                send_gap = draw_gap(send_steady);
            end
            if (!push_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_samples.size() > 0) begin
                    i_sample  <= pending_samples.pop_front();
                    push_next = 1'b1;
                end
            end
            i_push <= push_next;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop       <= 1'b0;
            take_gap    = 0;
            take_steady = 1'b0;
        end else begin
            pop_next = i_pop;
            if (i_pop && !o_empty) begin
                if (pool_results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected item: value %0d index %0d eop %0b",
                                 o_pooled_value, o_source_index, o_end_of_plane);
                    mismatches++;
                end else if (o_pooled_value !== pool_results_due[0].value ||
                             o_source_index !== pool_results_due[0].index ||
                             o_end_of_plane !== pool_results_due[0].eop) begin
                    if (mismatches < 10)
                        $display("mismatch: expected value %0d index %0d eop %0b, got %0d %0d %0b",
                                 pool_results_due[0].value, pool_results_due[0].index,
                                 pool_results_due[0].eop, o_pooled_value, o_source_index,
                                 o_end_of_plane);
                    mismatches++;
                    void'(pool_results_due.pop_front());
                end else begin
                    void'(pool_results_due.pop_front());
                end
                pop_next = 1'b0;
                if ($urandom_range(0, 63) == 0) take_steady = !take_steady;
                take_gap = draw_gap(take_steady);
            end
            if (!pop_next) begin
                if (take_gap > 0) take_gap--;
                else pop_next = 1'b1;
            end
            i_pop <= pop_next;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty) || i_cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("max_pool_2d_argmax_test: FAIL");
            $finish;
        end
    end

    task automatic queue_sample(input logic signed [SW-1:0] s);
        pending_samples.push_back(s);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || pool_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    task automatic finish_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_sizes(input int w, input int h, input int pw, input int ph);
        write_register(CFG_INPUT_WIDTH, CFG_DATA_W'(w));
        write_register(CFG_INPUT_HEIGHT, CFG_DATA_W'(h));
        write_register(CFG_POOL_WIDTH, CFG_DATA_W'(pw));
        write_register(CFG_POOL_HEIGHT, CFG_DATA_W'(ph));
        finish_writes();
    endtask

    initial begin
        int                    random_items;
        int                    n, plane;
        int unsigned           cur_w, cur_h;
        bit                    first;
        logic [CFG_DATA_W-1:0] data;
        t_sample_mode          mode;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default sizes: two rows of a 32 x 32 plane
        repeat (64) queue_sample(draw_sample(SAMPLES_ANY));
        wait_idle();

        // 3 x 3 plane, 2 x 2 windows: partial right and bottom windows, ties
        write_sizes(3, 3, 2, 2);
        queue_sample(16'sd7);
        queue_sample(16'sd7);
        queue_sample(16'sh8000);
        queue_sample(16'sh8000);
        queue_sample(16'sd7);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh7FFF);
        queue_sample(16'shFFFF);
        wait_idle();

        // zero registers act as 1: every item closes a plane
        write_sizes(0, 0, 0, 0);
        queue_sample(16'sh0000);
        queue_sample(16'shFFFF);
        queue_sample(16'sh7FFF);
        wait_idle();

        // oversize pool saturates: one window covers the plane
        write_sizes(5, 2, 31, 31);
        repeat (10) queue_sample(draw_sample(SAMPLES_TIES));
        wait_idle();

        random_items = 0;
        first        = 1'b1;
        cur_w        = 1;
        cur_h        = 1;
        while (random_items < RANDOM_ITEMS) begin
            if (first || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 15))
                    0:       data = '0;
                    1, 2:    data = CFG_DATA_W'($urandom_range(13, 64));
                    default: data = CFG_DATA_W'($urandom_range(1, 12));
                endcase
                write_register(CFG_INPUT_WIDTH, data);
                cur_w = clamp_size(data, DEF_MAX_WIDTH);
            end
            if (first || $urandom_range(0, 3) != 0) begin
                data = ($urandom_range(0, 15) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
                write_register(CFG_INPUT_HEIGHT, data);
                cur_h = clamp_size(data, DEF_MAX_HEIGHT);
            end
            if (first || $urandom_range(0, 3) != 0) begin
                data = {($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0, pick_pool()};
                write_register(CFG_POOL_WIDTH, data);
            end
            if (first || $urandom_range(0, 3) != 0) begin
                data = {($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0, pick_pool()};
                write_register(CFG_POOL_HEIGHT, data);
            end
            finish_writes();
            first = 1'b0;

            plane = cur_w * cur_h;
            n     = plane * $urandom_range(1, 3) + $urandom_range(0, plane);
            if (n > 240) n = $urandom_range(120, 240);
            case ($urandom_range(0, 19))
                0, 1, 2:       mode = SAMPLES_EXTREME;
                3, 4, 5, 6, 7: mode = SAMPLES_TIES;
                default:       mode = SAMPLES_ANY;
            endcase
            repeat (n) queue_sample(draw_sample(mode));
            random_items += n;
            wait_idle();
        end

        if (mismatches == 0 && pool_results_due.size() == 0) begin
            $display("max_pool_2d_argmax_test: PASS");
        end else begin
            $display("max_pool_2d_argmax_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- max_pool_2d_argmax.f -----
rtl/mp2a_pkg.sv
rtl/mp2a_fifo.sv
rtl/mp2a_ram.sv
rtl/mp2a_front.sv
rtl/mp2a_back.sv
rtl/max_pool_2d_argmax.sv
sim/max_pool_2d_argmax_test.sv
